>>> src/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg
// Operation codes, fault codes, divider sizing and the side-band word that
// travels with each item through the divider pipeline.
// ----------------------------------------------------------------------------
package cca_pkg;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_CMP  = 4'd2;
	localparam logic [3:0] OP_NEG  = 4'd3;
	localparam logic [3:0] OP_NEGX = 4'd4;
	localparam logic [3:0] OP_TST  = 4'd5;
	localparam logic [3:0] OP_MULU = 4'd6;
	localparam logic [3:0] OP_MULS = 4'd7;
	localparam logic [3:0] OP_ADDX = 4'd8;
	localparam logic [3:0] OP_SUBX = 4'd9;
	localparam logic [3:0] OP_ABCD = 4'd10;
	localparam logic [3:0] OP_SBCD = 4'd11;
	localparam logic [3:0] OP_NBCD = 4'd12;
	localparam logic [3:0] OP_DIVU = 4'd13;
	localparam logic [3:0] OP_DIVS = 4'd14;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_WORD = 2'd1;
	localparam logic [1:0] SZ_LONG = 2'd2;

	localparam logic [1:0] FLT_OK   = 2'd0;
	localparam logic [1:0] FLT_DIV0 = 2'd1;
	localparam logic [1:0] FLT_OVF  = 2'd2;

	// flag bit positions: X N Z V C
	localparam int FX = 4;
	localparam int FN = 3;
	localparam int FZ = 2;
	localparam int FV = 1;
	localparam int FC = 0;

	// divider: 32 quotient bits, four per stage
	localparam int DIV_STAGES = 8;
	localparam int DIV_STEP   = 4;

	typedef struct packed {
		logic [3:0]  op;
		logic [31:0] alu_r;
		logic [4:0]  alu_f;
		logic        alu_wr;
		logic [4:0]  fin;
		logic        dneg;
		logic        sneg;
		logic        dv_zero;
	} cca_side_t;

endpackage

>>> src/cca_div_pipe.sv
// ----------------------------------------------------------------------------
// cca_div_pipe
// Pipelined unsigned 32/16 restoring divider, four quotient bits per stage.
// A side-band word rides along with each item.
// ----------------------------------------------------------------------------
module cca_div_pipe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [31:0]        dmag,
	input  logic [15:0]        smag,
	input  cca_pkg::cca_side_t side_in,
	output logic               out_valid,
	output logic [31:0]        quot,
	output logic [15:0]        rem,
	output cca_pkg::cca_side_t side_out
);
	import cca_pkg::*;

	logic      vld_s  [DIV_STAGES];
	logic [15:0] rem_s [DIV_STAGES];
	logic [31:0] dd_s  [DIV_STAGES];
	logic [15:0] sm_s  [DIV_STAGES];
	cca_side_t side_s  [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic        v_in;
		logic [15:0] r_in;
		logic [31:0] d_in;
		logic [15:0] s_in;
		cca_side_t   sd_in;
		logic [15:0] r_nx;
		logic [31:0] d_nx;

		// pick the previous stage or the entry ports
		if (g == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = 16'd0;
			assign d_in  = dmag;
			assign s_in  = smag;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = vld_s[g-1];
			assign r_in  = rem_s[g-1];
			assign d_in  = dd_s[g-1];
			assign s_in  = sm_s[g-1];
			assign sd_in = side_s[g-1];
		end

		// shift, trial subtract, restore
		always_comb begin
			logic [16:0] t;
			logic        qb;
			r_nx = r_in;
			d_nx = d_in;
			for (int j = 0; j < DIV_STEP; j++) begin
				t  = {r_nx, d_nx[31]};
				qb = (t >= {1'b0, s_in});
				r_nx = qb ? 16'(t - {1'b0, s_in}) : t[15:0];
				d_nx = {d_nx[30:0], qb};
			end
		end

		// advance stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= r_nx;
				dd_s[g]   <= d_nx;
				sm_s[g]   <= s_in;
				side_s[g] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quot      = dd_s[DIV_STAGES-1];
	assign rem       = rem_s[DIV_STAGES-1];
	assign side_out  = side_s[DIV_STAGES-1];

`ifndef SYNTH
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (vld_s[DIV_STAGES-1] == $past(vld_s[DIV_STAGES-2])))
		else $error("divider valid lost between stages");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dd_s[DIV_STAGES-1]) && $stable(vld_s[DIV_STAGES-1]))
		else $error("divider advanced while stalled");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && sm_s[0] != 16'd0 |-> rem_s[0] < sm_s[0])
		else $error("partial remainder not below divisor");
`endif

endmodule

>>> src/cisc_alu_with_condition_codes.sv
// ----------------------------------------------------------------------------
// cisc_alu_with_condition_codes
// 68000-style ALU with X/N/Z/V/C flags, 16x16 multiply, BCD and 32/16 divide.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input word passes through ten registers before result valid
//   (entry stage, eight divider stages of four quotient bits, output).
// Throughput: one word per cycle; the whole pipeline holds on output stall.
// Reset: arst_n clears all valid bits at once; payload registers keep junk.
module cisc_alu_with_condition_codes (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  operation,
	input  logic [1:0]  size_code,
	input  logic [31:0] source_operand,
	input  logic [31:0] dest_operand,
	input  logic [4:0]  flags_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_value,
	output logic [4:0]  flags_out,
	output logic        writes_result,
	output logic [1:0]  fault_status
);
	import cca_pkg::*;

	logic        en;
	logic        valid_q;
	logic [31:0] r_q;
	logic [4:0]  f_q;
	logic        wr_q;
	logic [1:0]  flt_q;

	assign en       = !valid_q || out_ready;
	assign in_ready = en;

	// ALU work in the entry stage
	cca_side_t   side_c;
	logic [31:0] dmag_c;
	logic [15:0] smag_c;

	always_comb begin
		logic [31:0] mask, msb, sm, dm, r, ss, ds;
		logic [32:0] wide;
		logic        xin, bin, cy, n, v, zs;
		logic [31:0] prod_u;
		logic signed [31:0] prod_s;
		logic [9:0]  lo, hi;
		logic [7:0]  bs, bd, br;
		logic        bcy;
		logic [15:0] dv;

		case (size_code)
			SZ_BYTE: mask = 32'h0000_00FF;
			SZ_WORD: mask = 32'h0000_FFFF;
			default: mask = 32'hFFFF_FFFF;
		endcase
		msb = mask ^ (mask >> 1);
		xin = flags_in[FX];

		// shared subtract d - s - bin
		if (operation == OP_NEG || operation == OP_NEGX) begin
			ss = dest_operand;
			ds = 32'd0;
		end else begin
			ss = source_operand;
			ds = dest_operand;
		end
		bin = (operation == OP_NEGX || operation == OP_SUBX) ? xin : 1'b0;

		if (operation == OP_ADD || operation == OP_ADDX) begin
			sm   = source_operand & mask;
			dm   = dest_operand & mask;
			wide = {1'b0, dm} + {1'b0, sm} + {32'd0, bin | (operation == OP_ADDX && xin)};
			r    = wide[31:0] & mask;
			cy   = |(wide & ~{1'b0, mask});
			v    = |(~(source_operand ^ dest_operand) & (source_operand ^ r) & msb);
		end else begin
			sm   = ss & mask;
			dm   = ds & mask;
			wide = {1'b0, sm} + {32'd0, bin};
			r    = (dm - sm - {31'd0, bin}) & mask;
			cy   = wide > {1'b0, dm};
			v    = |((ss ^ ds) & (ds ^ r) & msb);
		end
		n  = |(r & msb);
		zs = (r != 32'd0) ? 1'b0 : flags_in[FZ];

		prod_u = 32'(source_operand[15:0] * dest_operand[15:0]);
		prod_s = $signed(source_operand[15:0]) * $signed(dest_operand[15:0]);

		// BCD digit arithmetic
		bd = (operation == OP_NBCD) ? 8'd0 : dest_operand[7:0];
		bs = (operation == OP_NBCD) ? dest_operand[7:0] : source_operand[7:0];
		bcy = 1'b0;
		if (operation == OP_ABCD) begin
			lo = {6'd0, bd[3:0]} + {6'd0, bs[3:0]} + {9'd0, xin};
			hi = {2'd0, bd & 8'hF0} + {2'd0, bs & 8'hF0};
			if (lo > 10'd9) lo = lo + 10'd6;
			hi = hi + (lo & 10'h0F0);
			if (hi > 10'h090) begin
				hi  = hi + 10'h060;
				bcy = 1'b1;
			end
		end else begin
			lo = {6'd0, bd[3:0]} - {6'd0, bs[3:0]} - {9'd0, xin};
			hi = {2'd0, bd & 8'hF0} - {2'd0, bs & 8'hF0};
			if (lo[9]) begin
				lo = lo + 10'd10;
				hi = hi - 10'h010;
			end
			if (hi[9]) begin
				hi  = hi + 10'h0A0;
				bcy = 1'b1;
			end
		end
		br = {hi[7:4], lo[3:0]};

		side_c.op      = operation;
		side_c.fin     = flags_in;
		side_c.alu_wr  = 1'b1;
		side_c.alu_r   = r;
		side_c.alu_f   = {cy, n, r == 32'd0, v, cy};
		case (operation)
			OP_ADD, OP_SUB, OP_NEG: ;
			OP_CMP: begin
				side_c.alu_f[FX] = xin;
				side_c.alu_wr    = 1'b0;
			end
			OP_NEGX, OP_ADDX, OP_SUBX: side_c.alu_f[FZ] = zs;
			OP_TST: begin
				side_c.alu_r  = dest_operand & mask;
				side_c.alu_f  = {xin, |(dest_operand & msb),
					(dest_operand & mask) == 32'd0, 2'b00};
				side_c.alu_wr = 1'b0;
			end
			OP_MULU: begin
				side_c.alu_r = prod_u;
				side_c.alu_f = {xin, prod_u[31], prod_u == 32'd0, 2'b00};
			end
			OP_MULS: begin
				side_c.alu_r = prod_s;
				side_c.alu_f = {xin, prod_s[31], prod_s == 32'sd0, 2'b00};
			end
			OP_ABCD, OP_SBCD, OP_NBCD: begin
				side_c.alu_r = {24'd0, br};
				side_c.alu_f = {bcy, 1'b0,
					(br != 8'd0) ? 1'b0 : flags_in[FZ], 1'b0, bcy};
			end
			OP_DIVU, OP_DIVS: ;
			default: begin
				side_c.alu_r  = 32'd0;
				side_c.alu_f  = flags_in;
				side_c.alu_wr = 1'b0;
			end
		endcase

		// divider operand magnitudes
		dv             = source_operand[15:0];
		side_c.dv_zero = (dv == 16'd0);
		side_c.dneg    = (operation == OP_DIVS) && dest_operand[31];
		side_c.sneg    = (operation == OP_DIVS) && dv[15];
		dmag_c         = side_c.dneg ? (32'd0 - dest_operand) : dest_operand;
		smag_c         = side_c.sneg ? (16'd0 - dv) : dv;
	end

	// entry stage register
	logic        valid_s1;
	cca_side_t   side_s1;
	logic [31:0] dmag_s1;
	logic [15:0] smag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			dmag_s1 <= dmag_c;
			smag_s1 <= smag_c;
		end
	end

	logic        dvalid;
	logic [31:0] dquot;
	logic [15:0] drem;
	cca_side_t   dside;

	cca_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s1),
		.dmag     (dmag_s1),
		.smag     (smag_s1),
		.side_in  (side_s1),
		.out_valid(dvalid),
		.quot     (dquot),
		.rem      (drem),
		.side_out (dside)
	);

	// finish division and select the result
	logic [31:0] r_c;
	logic [4:0]  f_c;
	logic        wr_c;
	logic [1:0]  flt_c;

	always_comb begin
		logic        qneg, ovf;
		logic [31:0] q;
		logic [15:0] rm;
		qneg = dside.dneg ^ dside.sneg;
		if (dside.op == OP_DIVS) begin
			ovf = qneg ? (dquot > 32'd32768) : (dquot > 32'd32767);
			q   = qneg ? (32'd0 - dquot) : dquot;
			rm  = dside.dneg ? (16'd0 - drem) : drem;
		end else begin
			ovf = dquot[31:16] != 16'd0;
			q   = dquot;
			rm  = drem;
		end
		r_c   = dside.alu_r;
		f_c   = dside.alu_f;
		wr_c  = dside.alu_wr;
		flt_c = FLT_OK;
		if (dside.op == OP_DIVU || dside.op == OP_DIVS) begin
			if (dside.dv_zero) begin
				r_c   = 32'd0;
				f_c   = dside.fin;
				wr_c  = 1'b0;
				flt_c = FLT_DIV0;
			end else if (ovf) begin
				r_c   = 32'd0;
				f_c   = {dside.fin[FX], q[15], 1'b0, 1'b1, 1'b0};
				wr_c  = 1'b0;
				flt_c = FLT_OVF;
			end else begin
				r_c   = {rm, q[15:0]};
				f_c   = {dside.fin[FX], q[15], q[15:0] == 16'd0, 2'b00};
				wr_c  = 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= dvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q   <= r_c;
			f_q   <= f_c;
			wr_q  <= wr_c;
			flt_q <= flt_c;
		end
	end

	assign out_valid     = valid_q;
	assign result_value  = r_q;
	assign flags_out     = f_q;
	assign writes_result = wr_q;
	assign fault_status  = flt_q;

`ifndef SYNTH
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (flt_q != 2'd3))
		else $error("undefined fault code");
	a_fault_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && flt_q != FLT_OK |-> !wr_q && r_q == 32'd0)
		else $error("faulted division writes a result");
	a_ovf_v: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && flt_q == FLT_OVF |-> f_q[FV] && !f_q[FZ] && !f_q[FC])
		else $error("quotient overflow flags wrong");
`endif

endmodule
